FILE: src/ffa_pkg.sv
package ffa_pkg;

    // Default sizing of the managed region.
    localparam int REGION_BYTES_DEF   = 65536;
    localparam int MAX_ALIGN_LOG2_DEF = 12;
    localparam int HDR_BYTES          = 8;

    // Request kinds.
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_PROBE = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;
    localparam logic [1:0] ST_BADSIZE = 2'd3;

    // Header memory read address select.
    localparam logic [0:0] RD_CUR  = 1'd0;
    localparam logic [0:0] RD_NEXT = 1'd1;

    // Header memory write select.
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_INIT  = 3'd1;
    localparam logic [2:0] WR_FRONT = 3'd2;
    localparam logic [2:0] WR_USED  = 3'd3;
    localparam logic [2:0] WR_TAIL  = 3'd4;
    localparam logic [2:0] WR_FREE  = 3'd5;
    localparam logic [2:0] WR_PREV  = 3'd6;

    // Running total update select.
    localparam logic [1:0] TOT_NONE  = 2'd0;
    localparam logic [1:0] TOT_ALLOC = 2'd1;
    localparam logic [1:0] TOT_FREE  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       ld_req;
        logic [0:0] rd_sel;
        logic       eval;
        logic       cap_next;
        logic       step;
        logic [2:0] wr_sel;
        logic [1:0] tot_sel;
        logic       ld_out;
        logic [1:0] out_st;
        logic       out_addr;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req;
        logic       bad_size;
        logic       fit;
        logic       at_end;
        logic       at_target;
        logic       past_target;
        logic       blk_used;
        logic       out_free;
    } sts_t;

endpackage

FILE: src/ffa_ctrl.sv
module ffa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  ffa_pkg::sts_t sts,
    output ffa_pkg::cmd_t cmd
);
    import ffa_pkg::*;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_EV   = 4'd4;
    localparam logic [3:0] S_CK   = 4'd5;
    localparam logic [3:0] S_W1   = 4'd6;
    localparam logic [3:0] S_W2   = 4'd7;
    localparam logic [3:0] S_W3   = 4'd8;
    localparam logic [3:0] S_RN   = 4'd9;
    localparam logic [3:0] S_RNV  = 4'd10;
    localparam logic [3:0] S_FW   = 4'd11;
    localparam logic [3:0] S_FP   = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic       addr_reg, addr_next;

    assign req_ready = (state_reg == S_IDLE);

    // State register, the pending result code and the address flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            st_reg    <= ST_OK;
            addr_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            addr_reg  <= addr_next;
        end
    end

    // Sequencing of the walk, the updates and the result.
    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        addr_next  = addr_reg;
        cmd        = '0;
        cmd.rd_sel = RD_CUR;
        cmd.wr_sel = WR_NONE;
        cmd.tot_sel = TOT_NONE;
        cmd.out_st = st_reg;
        cmd.out_addr = addr_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.wr_sel = WR_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (req_valid) begin
                    cmd.ld_req = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                st_next   = ST_OK;
                addr_next = 1'b0;
                if (sts.req == REQ_NONE) begin
                    state_next = S_FIN;
                end else if (sts.req != REQ_FREE && sts.bad_size) begin
                    st_next    = ST_BADSIZE;
                    state_next = S_FIN;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                cmd.eval   = 1'b1;
                state_next = S_CK;
            end
            S_CK: begin
                if (sts.req == REQ_FREE) begin
                    if (sts.at_target) begin
                        if (sts.blk_used) begin
                            state_next = S_RN;
                        end else begin
                            st_next    = ST_BADADDR;
                            state_next = S_FIN;
                        end
                    end else if (sts.past_target || sts.at_end) begin
                        st_next    = ST_BADADDR;
                        state_next = S_FIN;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = S_RD;
                    end
                end else begin
                    if (sts.fit) begin
                        state_next = (sts.req == REQ_ALLOC) ? S_W1 : S_FIN;
                    end else if (sts.at_end) begin
                        st_next    = ST_NOSPACE;
                        state_next = S_FIN;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_W1: begin
                cmd.wr_sel = WR_FRONT;
                state_next = S_W2;
            end
            S_W2: begin
                cmd.wr_sel = WR_USED;
                state_next = S_W3;
            end
            S_W3: begin
                cmd.wr_sel  = WR_TAIL;
                cmd.tot_sel = TOT_ALLOC;
                addr_next   = 1'b1;
                state_next  = S_FIN;
            end
            S_RN: begin
                cmd.rd_sel = RD_NEXT;
                state_next = S_RNV;
            end
            S_RNV: begin
                cmd.cap_next = 1'b1;
                state_next   = S_FW;
            end
            S_FW: begin
                cmd.wr_sel = WR_FREE;
                state_next = S_FP;
            end
            S_FP: begin
                cmd.wr_sel  = WR_PREV;
                cmd.tot_sel = TOT_FREE;
                state_next  = S_FIN;
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A result is only reported with an address after an allocation pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out && cmd.out_addr |-> cmd.out_st == ST_OK && sts.req == REQ_ALLOC)
        else $error("address reported for a request that did not allocate");

    // A request word is taken only while idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_req |-> state_reg == S_IDLE && req_valid)
        else $error("request taken outside idle");

    // The state register never holds an unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= S_FIN)
        else $error("illegal controller state");

endmodule

FILE: src/ffa_dp.sv
module ffa_dp #(
    parameter int REGION_BYTES   = ffa_pkg::REGION_BYTES_DEF,
    parameter int MAX_ALIGN_LOG2 = ffa_pkg::MAX_ALIGN_LOG2_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ffa_pkg::cmd_t cmd,
    output ffa_pkg::sts_t sts,
    input  logic [1:0]    in_req,
    input  logic [15:0]   in_size,
    input  logic [3:0]    in_align,
    input  logic [15:0]   in_address,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [1:0]    out_status,
    output logic [15:0]   out_block_address,
    output logic [15:0]   out_free_bytes,
    output logic [15:0]   out_used_bytes
);
    import ffa_pkg::*;

    localparam int WORDS = REGION_BYTES / HDR_BYTES;
    localparam int AW    = $clog2(WORDS);
    localparam int BW    = $clog2(REGION_BYTES + 1);
    localparam int HW    = BW + 1;
    localparam int MW    = (BW > MAX_ALIGN_LOG2 + 1) ? BW : MAX_ALIGN_LOG2 + 1;
    localparam int CW    = ((MW > 17) ? MW : 17) + 2;
    localparam logic [CW-1:0] HDR_C  = CW'(HDR_BYTES);
    localparam logic [CW-1:0] REGION = CW'(REGION_BYTES);
    localparam logic [CW-1:0] CAP    = CW'(REGION_BYTES - HDR_BYTES);
    localparam logic [3:0]    ALIGN_MAX = 4'((MAX_ALIGN_LOG2 > 15) ? 15 : MAX_ALIGN_LOG2);
    localparam logic [3:0]    ALIGN_MIN = 4'd3;

    // Header memory, one signed length per 8 bytes.
    logic signed [HW-1:0] mem [WORDS];
    logic [HW-1:0] rdata_reg;

    logic [1:0]    req_reg;
    logic [CW-1:0] sz_reg, mask_reg, target_reg;
    logic          tgt_ok_reg;
    logic [CW-1:0] b_reg, prev_reg, next_reg, len_reg, gap_reg, cur_reg;
    logic [HW-1:0] h_reg, prev_h_reg;
    logic          have_prev_reg, merge_n_reg;
    logic [BW-1:0] free_reg, used_reg;
    logic          ov_reg;
    logic [1:0]    ost_reg;
    logic [15:0]   oaddr_reg, ofree_reg, oused_reg;

    // Request decode values.
    logic [CW-1:0] sz_in, mask_in;
    logic [3:0]    al_in;
    always_comb begin
        sz_in = (CW'(in_size) + CW'(7)) & ~CW'(7);
        if (in_align < ALIGN_MIN) begin
            al_in = ALIGN_MIN;
        end else if (in_align > ALIGN_MAX) begin
            al_in = ALIGN_MAX;
        end else begin
            al_in = in_align;
        end
        mask_in = (CW'(1) << al_in) - CW'(1);
    end

    // Length, aligned gap and split sizes of the header just read.
    logic [CW-1:0] rd_len, s_cur, sb_cur, gap_cur, sb, lenb, tail, ulen, front;
    logic          split;
    always_comb begin
        rd_len  = rdata_reg[HW-1] ? CW'(HW'(-rdata_reg)) : CW'(rdata_reg);
        s_cur   = b_reg + HDR_C;
        sb_cur  = ((s_cur & mask_reg) != '0) ? ((s_cur + HDR_C + mask_reg) & ~mask_reg)
                                              : s_cur;
        gap_cur = sb_cur - s_cur;
        sb      = b_reg + HDR_C + gap_reg;
        lenb    = len_reg - gap_reg;
        split   = (lenb - sz_reg) > HDR_C;
        tail    = split ? (lenb - sz_reg - HDR_C) : '0;
        ulen    = split ? sz_reg : lenb;
        front   = (gap_reg != '0) ? (gap_reg - HDR_C) : '0;
    end

    // Status to the controller.
    always_comb begin
        sts.req         = req_reg;
        sts.bad_size    = (sz_reg == '0) || (sz_reg > CAP);
        sts.fit         = !h_reg[HW-1] && (len_reg >= sz_reg) && (gap_reg <= len_reg)
                          && ((len_reg - gap_reg) >= sz_reg);
        sts.at_end      = (next_reg >= REGION);
        sts.at_target   = tgt_ok_reg && (b_reg == target_reg);
        sts.past_target = !tgt_ok_reg || (b_reg > target_reg);
        sts.blk_used    = h_reg[HW-1];
        sts.out_free    = !ov_reg || out_ready;
    end

    // Memory port selection.
    logic [AW-1:0] rd_idx, wr_idx;
    logic [HW-1:0] wr_data;
    logic          wr_en;
    always_comb begin
        rd_idx  = (cmd.rd_sel == RD_NEXT) ? next_reg[AW+2:3] : b_reg[AW+2:3];
        wr_en   = 1'b0;
        wr_idx  = b_reg[AW+2:3];
        wr_data = HW'(cur_reg);
        case (cmd.wr_sel)
            WR_INIT: begin
                wr_en   = 1'b1;
                wr_idx  = '0;
                wr_data = HW'(CAP);
            end
            WR_FRONT: begin
                wr_en   = (gap_reg != '0);
                wr_data = HW'(front);
            end
            WR_USED: begin
                wr_en   = 1'b1;
                wr_idx  = AW'((sb - HDR_C) >> 3);
                wr_data = HW'(-ulen);
            end
            WR_TAIL: begin
                wr_en   = split;
                wr_idx  = AW'((sb + sz_reg) >> 3);
                wr_data = HW'(tail);
            end
            WR_FREE: begin
                wr_en = 1'b1;
            end
            WR_PREV: begin
                wr_en   = have_prev_reg && !prev_h_reg[HW-1];
                wr_idx  = prev_reg[AW+2:3];
                wr_data = prev_h_reg + HW'(HDR_BYTES) + HW'(cur_reg);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_idx];
    end

    // Request capture and walk registers.
    always_ff @(posedge aclk) begin
        if (cmd.ld_req) begin
            req_reg       <= in_req;
            sz_reg        <= sz_in;
            mask_reg      <= mask_in;
            tgt_ok_reg    <= (in_address >= 16'(HDR_BYTES));
            target_reg    <= CW'(in_address) - HDR_C;
            b_reg         <= '0;
            have_prev_reg <= 1'b0;
        end
        if (cmd.eval) begin
            h_reg    <= rdata_reg;
            len_reg  <= rd_len;
            next_reg <= b_reg + HDR_C + rd_len;
            gap_reg  <= gap_cur;
        end
        if (cmd.step) begin
            prev_reg      <= b_reg;
            prev_h_reg    <= h_reg;
            have_prev_reg <= 1'b1;
            b_reg         <= next_reg;
        end
        if (cmd.cap_next) begin
            merge_n_reg <= (next_reg < REGION) && !rdata_reg[HW-1];
            cur_reg     <= ((next_reg < REGION) && !rdata_reg[HW-1])
                           ? len_reg + HDR_C + CW'(rdata_reg) : len_reg;
        end
    end

    // Running totals.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= BW'(CAP);
            used_reg <= '0;
        end else if (cmd.tot_sel == TOT_ALLOC) begin
            free_reg <= BW'(CW'(free_reg) - len_reg + front + tail);
            used_reg <= BW'(CW'(used_reg) + ulen);
        end else if (cmd.tot_sel == TOT_FREE) begin
            free_reg <= BW'(CW'(free_reg) + len_reg
                        + (merge_n_reg ? HDR_C : '0)
                        + ((have_prev_reg && !prev_h_reg[HW-1]) ? HDR_C : '0));
            used_reg <= BW'(CW'(used_reg) - len_reg);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.ld_out) begin
            ov_reg <= 1'b1;
        end else if (out_ready) begin
            ov_reg <= 1'b0;
        end
        if (cmd.ld_out) begin
            ost_reg   <= cmd.out_st;
            oaddr_reg <= cmd.out_addr ? 16'(sb) : '0;
            ofree_reg <= 16'(free_reg);
            oused_reg <= 16'(used_reg);
        end
    end

    assign out_valid         = ov_reg;
    assign out_status        = ost_reg;
    assign out_block_address = oaddr_reg;
    assign out_free_bytes    = ofree_reg;
    assign out_used_bytes    = oused_reg;

    // Totals never exceed the region less one header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(free_reg) + CW'(used_reg) <= CAP)
        else $error("free and used totals exceed the region");

    // An allocated data start is word aligned and past its header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out && cmd.out_addr |-> sb[2:0] == 3'd0 && sb >= HDR_C)
        else $error("allocated address misaligned");

    // A free never grows the used total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tot_sel == TOT_FREE |=> used_reg <= $past(used_reg))
        else $error("used total grew on free");

endmodule

FILE: src/first_fit_aligned_allocator.sv
// Channel  Direction  Contents
// s_       in         tuser: req_type; tdata: size, align_log2, address
// m_       out        tuser: status; tdata: block_address, free_bytes, used_bytes
//
// Requests walk the block chain one header at a time in three steps (memory read, length
// and alignment evaluation, fit check), framed by accept, decode and result load steps;
// an allocate adds three header writes, and a free adds a next-header read, its capture and
// two writes; time grows with the number of blocks passed.
// After reset the first header is initialized before s_tready rises.
// One request is in flight at a time; a result held on a stalled m_ side blocks
// only the completion of the next request.
module first_fit_aligned_allocator #(
    parameter int REGION_BYTES   = ffa_pkg::REGION_BYTES_DEF,
    parameter int MAX_ALIGN_LOG2 = ffa_pkg::MAX_ALIGN_LOG2_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type
    input  logic [39:0] s_tdata,   // size[15:0], align_log2[19:16], address[35:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // status
    output logic [47:0] m_tdata    // block_address[15:0], free_bytes[31:16], used[47:32]
);
    import ffa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    ffa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Header memory, walk registers and totals.
    ffa_dp #(
        .REGION_BYTES   (REGION_BYTES),
        .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .in_req            (s_tuser),
        .in_size           (s_tdata[15:0]),
        .in_align          (s_tdata[19:16]),
        .in_address        (s_tdata[35:20]),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_status        (m_tuser),
        .out_block_address (m_tdata[15:0]),
        .out_free_bytes    (m_tdata[31:16]),
        .out_used_bytes    (m_tdata[47:32])
    );

endmodule

FILE: tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int REGION = 65536;
    localparam int MAXAL = 12;
    localparam int NWORDS = REGION / HDR_BYTES;
    localparam int CYCLE_LIMIT = 4000000;

    // One request word, or a marker that makes the sender wait for all results.
    typedef struct {
        bit          hold;
        logic [1:0]  req;
        logic [15:0] size;
        logic [3:0]  alog;
        logic [15:0] addr;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] blk;
        logic [15:0] free_b;
        logic [15:0] used_b;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [47:0] m_tdata;

    first_fit_aligned_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];
    int       heap_hdr[NWORDS];
    int       heap_free;
    int       heap_used;
    int       live_blocks[$];
    int       last_freed;
    int       error_count;
    int       words_sent;
    int       words_seen;
    int       burst_left;
    int       gap_left;
    int       hold_off;
    bit       hold_done;
    int       cycle_count;

    // Clock generation.
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic int hdr_rd(int off);
        return (off >> 3) < NWORDS ? heap_hdr[off >> 3] : 0;
    endfunction

    function automatic void hdr_wr(int off, int v);
        if ((off >> 3) < NWORDS) begin
            heap_hdr[off >> 3] = v;
        end
    endfunction

    function automatic int blen(int h);
        return h < 0 ? -h : h;
    endfunction

    // Rebuild the running totals by walking the chain.
    function automatic void retotal();
        int b;
        int fr;
        int us;
        int h;
        b = 0;
        fr = 0;
        us = 0;
        while (b < REGION) begin
            h = hdr_rd(b);
            if (h < 0) us += blen(h);
            else fr += h;
            b += HDR_BYTES + blen(h);
        end
        heap_free = fr & 32'h1FFFF;
        heap_used = us & 32'h1FFFF;
    endfunction

    // Applies one request to the heap image and gives the result it must produce.
    function automatic outcome_t heap_apply(request_t r);
        outcome_t o;
        int sz;
        int al;
        int alog;
        int b;
        int sb;
        int s;
        int h;
        int len;
        int lenb;
        int prev;
        int cur;
        int n;
        bit found;
        bit have_prev;
        bit done;
        o.status = ST_OK;
        o.blk = '0;
        alog = r.alog;
        if (alog < 3) alog = 3;
        if (alog > MAXAL) alog = MAXAL;
        if (r.req == REQ_ALLOC || r.req == REQ_PROBE) begin
            sz = (int'(r.size) + 7) & ~7;
            al = 1 << alog;
            if (sz == 0 || sz > REGION - HDR_BYTES) begin
                o.status = ST_BADSIZE;
            end else begin
                // First-fit walk, allowing for an aligned carve inside the block.
                found = 1'b0;
                b = 0;
                while (b < REGION && !found) begin
                    h = hdr_rd(b);
                    len = blen(h);
                    if (h >= 0 && len >= sz) begin
                        s = b + HDR_BYTES;
                        sb = s;
                        if ((s & (al - 1)) != 0) sb = (s + HDR_BYTES + al - 1) & ~(al - 1);
                        if (sb - s <= len && len - (sb - s) >= sz) found = 1'b1;
                    end
                    if (!found) b += HDR_BYTES + len;
                end
                if (!found) begin
                    o.status = ST_NOSPACE;
                end else if (r.req == REQ_ALLOC) begin
                    s = b + HDR_BYTES;
                    len = blen(hdr_rd(b));
                    lenb = len - (sb - s);
                    if (sb != s) hdr_wr(b, sb - HDR_BYTES - s);
                    if (lenb - sz <= HDR_BYTES) begin
                        hdr_wr(sb - HDR_BYTES, -lenb);
                    end else begin
                        hdr_wr(sb - HDR_BYTES, -sz);
                        hdr_wr(sb + sz, lenb - sz - HDR_BYTES);
                    end
                    o.blk = sb[15:0];
                    retotal();
                end
            end
        end else if (r.req == REQ_FREE) begin
            b = 0;
            prev = 0;
            have_prev = 1'b0;
            done = 1'b0;
            o.status = ST_BADADDR;
            while (b < REGION && !done) begin
                h = hdr_rd(b);
                if (r.addr >= HDR_BYTES && b == int'(r.addr) - HDR_BYTES) begin
                    done = 1'b1;
                    if (h < 0) begin
                        // Merge with a free successor, then into a free predecessor.
                        cur = blen(h);
                        n = b + HDR_BYTES + cur;
                        if (n < REGION && hdr_rd(n) >= 0) cur += HDR_BYTES + hdr_rd(n);
                        hdr_wr(b, cur);
                        if (have_prev && hdr_rd(prev) >= 0)
                            hdr_wr(prev, hdr_rd(prev) + HDR_BYTES + cur);
                        o.status = ST_OK;
                        retotal();
                    end
                end else begin
                    prev = b;
                    have_prev = 1'b1;
                    b += HDR_BYTES + blen(h);
                end
            end
        end
        o.free_b = heap_free[15:0];
        o.used_b = heap_used[15:0];
        return o;
    endfunction

    task automatic queue_request(logic [1:0] req, int size, int alog, int addr);
        request_t r;
        outcome_t o;
        r.hold = 1'b0;
        r.req = req;
        r.size = size[15:0];
        r.alog = alog[3:0];
        r.addr = addr[15:0];
        o = heap_apply(r);
        if (req == REQ_ALLOC && o.status == ST_OK) live_blocks.push_back(int'(o.blk));
        pending_reqs.push_back(r);
        expected_outcomes.push_back(o);
    endtask

    task automatic free_live(int idx);
        int a;
        a = live_blocks[idx];
        live_blocks.delete(idx);
        last_freed = a;
        queue_request(REQ_FREE, 0, 0, a);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 words_seen, what, got, want);
        error_count++;
    endtask

    // Sender: bursts of words separated by random gaps; a hold marker waits for results.
    always @(posedge aclk) begin
        bit offering;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left = 4;
            gap_left = 0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                words_sent++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    if (pending_reqs[0].hold) begin
                        if (words_seen == words_sent) void'(pending_reqs.pop_front());
                    end else begin
                        request_t r;
                        r = pending_reqs.pop_front();
                        s_tuser <= r.req;
                        s_tdata <= {4'd0, r.addr, r.alog, r.size};
                        offering = 1'b1;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 30);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        end
                    end
                end
            end
            s_tvalid <= offering;
        end
    end

    // Receiver: random stalls, one long hold-off, and the field-by-field check.
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected word", int'(m_tdata[15:0]), 0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[15:0] !== want.blk)
                        report_mismatch("block_address", m_tdata[15:0], want.blk);
                    if (m_tdata[31:16] !== want.free_b)
                        report_mismatch("free_bytes", m_tdata[31:16], want.free_b);
                    if (m_tdata[47:32] !== want.used_b)
                        report_mismatch("used_bytes", m_tdata[47:32], want.used_b);
                end
                words_seen++;
            end
            if (!hold_done && words_seen == 400) begin
                hold_done = 1'b1;
                hold_off = 3000;
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if ((words_seen / 150) % 2 == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** first_fit_aligned_allocator: FAILED **");
            $finish;
        end
    end

    initial begin
        request_t marker;
        int total;
        int k;
        int pick;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        aresetn = 1'b0;
        error_count = 0;
        words_sent = 0;
        words_seen = 0;
        hold_off = 0;
        hold_done = 1'b0;
        cycle_count = 0;
        last_freed = 8;
        marker = '{hold: 1'b1, req: REQ_NONE, size: '0, alog: '0, addr: '0};
        foreach (heap_hdr[i]) heap_hdr[i] = 0;
        heap_hdr[0] = REGION - HDR_BYTES;
        heap_free = REGION - HDR_BYTES;
        heap_used = 0;

        // Directed requests: size, alignment and address extremes, every kind.
        queue_request(REQ_ALLOC, 0, 0, 0);
        queue_request(REQ_PROBE, 0, 3, 0);
        queue_request(REQ_ALLOC, 65535, 0, 0);
        queue_request(REQ_PROBE, 65529, 0, 0);
        queue_request(REQ_PROBE, 65528, 0, 0);
        queue_request(REQ_ALLOC, 65528, 15, 0);
        queue_request(REQ_ALLOC, 65528, 0, 0);
        queue_request(REQ_PROBE, 1, 0, 0);
        queue_request(REQ_ALLOC, 8, 0, 0);
        queue_request(REQ_FREE, 0, 0, 8);
        queue_request(REQ_FREE, 0, 0, 8);
        queue_request(REQ_ALLOC, 1, 0, 0);
        queue_request(REQ_ALLOC, 9, 4, 0);
        queue_request(REQ_ALLOC, 100, 15, 0);
        queue_request(REQ_ALLOC, 24, 12, 0);
        queue_request(REQ_FREE, 0, 0, 0);
        queue_request(REQ_FREE, 0, 0, 5);
        queue_request(REQ_FREE, 0, 0, 65535);
        queue_request(REQ_NONE, 16'hFFFF, 15, 16'hFFFF);
        queue_request(REQ_NONE, 0, 0, 0);
        pending_reqs.push_back(marker);
        while (live_blocks.size() > 0) free_live(0);

        // Random traffic: mostly alloc/free churn with a bounded number of live blocks.
        total = 1800;
        for (k = 0; k < total; k++) begin
            if (k == 900) pending_reqs.push_back(marker);
            pick = $urandom_range(0, 99);
            if (live_blocks.size() >= 40 || (pick >= 45 && pick < 80 && live_blocks.size() > 0)) begin
                free_live($urandom_range(0, live_blocks.size() - 1));
            end else if (pick < 45 || pick < 80) begin
                queue_request(REQ_ALLOC,
                              ($urandom_range(0, 19) == 0) ? $urandom_range(1, 20000)
                                                          : $urandom_range(1, 1024),
                              $urandom_range(0, 15), $urandom_range(0, 65535));
            end else if (pick < 88) begin
                queue_request(REQ_PROBE, $urandom_range(0, 65535), $urandom_range(0, 15),
                              $urandom_range(0, 65535));
            end else if (pick < 93) begin
                queue_request(REQ_FREE, $urandom_range(0, 65535), $urandom_range(0, 15),
                              $urandom_range(0, 65535));
            end else if (pick < 97) begin
                queue_request(REQ_FREE, 0, 0, last_freed);
            end else begin
                queue_request(REQ_NONE, $urandom_range(0, 65535), $urandom_range(0, 15),
                              $urandom_range(0, 65535));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && !s_tvalid && expected_outcomes.size() == 0);
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_outcomes.size() == 0) begin
            $display("** first_fit_aligned_allocator: PASSED **");
        end else begin
            $display("** first_fit_aligned_allocator: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
src/ffa_pkg.sv
src/ffa_ctrl.sv
src/ffa_dp.sv
src/first_fit_aligned_allocator.sv
tb/testbench.sv
